[rtl/clti_pkg.sv]
package clti_pkg;

    // Default widths of the time counter and of the normalised-time fraction
    localparam int TIME_BITS_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Positions are signed Q16.16 words
    localparam int POS_W = 32;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POSITION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DURATION  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE     = 2'd3;

    // Curve modes
    localparam logic MODE_CUBIC  = 1'b0;
    localparam logic MODE_LINEAR = 1'b1;

    // Pipeline depth outside the divider
    localparam int FRONT_STAGES = 2;
    localparam int POLY_STAGES  = 4;
    localparam int OUT_STAGES   = 1;

    // Control travelling alongside each sample
    typedef struct packed {
        logic valid;
        logic done;
    } t_ctl;

endpackage

[rtl/clti_front.sv]
module clti_front #(
    parameter int TIME_BITS     = clti_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = clti_pkg::FRACTION_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic [TIME_BITS-1:0]                    i_time,
    input  logic [TIME_BITS-1:0]                    i_duration,
    input  logic                                    i_curve_mode,
    input  logic [clti_pkg::POS_W-1:0]              i_delta_mag,
    output clti_pkg::t_ctl                          o_ctl,
    output logic [clti_pkg::POS_W+TIME_BITS-1:0]    o_numer
);

    localparam int NUM_W = clti_pkg::POS_W + TIME_BITS;

    logic                 r_valid;
    logic [TIME_BITS-1:0] r_time;
    clti_pkg::t_ctl       r_ctl;
    logic [NUM_W-1:0]     r_numer;

    logic                 w_done;
    logic [NUM_W-1:0]     w_prod;
    logic [NUM_W-1:0]     w_shift;
    clti_pkg::t_ctl       n_ctl;
    logic [NUM_W-1:0]     n_numer;

    // Capture the accepted time sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_time <= i_time;
    end

    // Detect end of move and form the dividend for the shared divider
    assign w_done  = (r_time >= i_duration);
    assign w_prod  = i_delta_mag * r_time;
    assign w_shift = {{(NUM_W-TIME_BITS){1'b0}}, r_time} << FRACTION_BITS;

    always_comb begin
        n_ctl.valid = r_valid;
        n_ctl.done  = w_done;
        n_numer     = (i_curve_mode == clti_pkg::MODE_LINEAR) ? w_prod : w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
        r_numer <= n_numer;
    end

    assign o_ctl   = r_ctl;
    assign o_numer = r_numer;

endmodule

[rtl/clti_div.sv]
module clti_div #(
    parameter int TIME_BITS = clti_pkg::TIME_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  clti_pkg::t_ctl                          i_ctl,
    input  logic [clti_pkg::POS_W+TIME_BITS-1:0]    i_numer,
    input  logic [TIME_BITS-1:0]                    i_divisor,
    output clti_pkg::t_ctl                          o_ctl,
    output logic [clti_pkg::POS_W-1:0]              o_quot,
    output logic                                    o_rem_nz
);

    localparam int STAGES = clti_pkg::POS_W;
    localparam int NUM_W  = clti_pkg::POS_W + TIME_BITS;

    clti_pkg::t_ctl       r_ctl [STAGES];
    logic [TIME_BITS-1:0] r_rem [STAGES];
    logic [STAGES-1:0]    r_dq  [STAGES];

    // One quotient bit per stage: shift the next dividend bit into the
    // remainder, subtract the divisor where it fits
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        clti_pkg::t_ctl       w_ctl_in;
        logic [TIME_BITS-1:0] w_rem_in;
        logic [STAGES-1:0]    w_dq_in;
        logic [TIME_BITS:0]   w_trial;
        logic [TIME_BITS:0]   w_diff;
        logic                 w_ge;

        if (g == 0) begin : g_first
            assign w_ctl_in = i_ctl;
            assign w_rem_in = i_numer[NUM_W-1:STAGES];
            assign w_dq_in  = i_numer[STAGES-1:0];
        end else begin : g_next
            assign w_ctl_in = r_ctl[g-1];
            assign w_rem_in = r_rem[g-1];
            assign w_dq_in  = r_dq[g-1];
        end

        assign w_trial = {w_rem_in, w_dq_in[STAGES-1]};
        assign w_ge    = (w_trial >= {1'b0, i_divisor});
        assign w_diff  = w_trial - {1'b0, i_divisor};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else begin
                r_ctl[g] <= w_ctl_in;
            end
            r_rem[g] <= w_ge ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
            r_dq[g]  <= {w_dq_in[STAGES-2:0], w_ge};
        end
    end

    assign o_ctl    = r_ctl[STAGES-1];
    assign o_quot   = r_dq[STAGES-1];
    assign o_rem_nz = |r_rem[STAGES-1];

    // A sample leaves the divider only if one entered it a full depth earlier
    a_div_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.valid |-> $past(i_ctl.valid, STAGES))
        else $error("divider produced a sample that never entered");

endmodule

[rtl/clti_poly.sv]
module clti_poly #(
    parameter int FRACTION_BITS = clti_pkg::FRACTION_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  clti_pkg::t_ctl                              i_ctl,
    input  logic [clti_pkg::POS_W-1:0]                  i_quot,
    input  logic                                        i_rem_nz,
    input  logic [clti_pkg::POS_W-1:0]                  i_delta_mag,
    output clti_pkg::t_ctl                              o_ctl,
    output logic [clti_pkg::POS_W+FRACTION_BITS:0]      o_prod,
    output logic [clti_pkg::POS_W-1:0]                  o_quot,
    output logic                                        o_rem_nz
);

    localparam int F      = FRACTION_BITS;
    localparam int PROD_W = clti_pkg::POS_W + F + 1;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    clti_pkg::t_ctl              r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic [clti_pkg::POS_W-1:0]  r1_quot, r2_quot, r3_quot, r4_quot;
    logic                        r1_rem_nz, r2_rem_nz, r3_rem_nz, r4_rem_nz;
    logic [F-1:0]                r1_t, r1_t2, r2_t2, r2_t3;
    logic [F:0]                  r3_s;
    logic [PROD_W-1:0]           r4_prod;

    logic [F-1:0]                w_t;
    logic [2*F-1:0]              w_tt;
    logic [2*F-1:0]              w_t2t;
    logic [F+1:0]                w_t2x3;
    logic [F+1:0]                w_t3x2;
    logic [F+1:0]                w_s_raw;
    logic [F:0]                  w_s;
    logic [PROD_W-1:0]           w_prod;

    // Square of the normalised time
    assign w_t  = i_quot[F-1:0];
    assign w_tt = w_t * w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
        r1_t      <= w_t;
        r1_t2     <= w_tt[2*F-1:F];
        r1_quot   <= i_quot;
        r1_rem_nz <= i_rem_nz;
    end

    // Cube of the normalised time
    assign w_t2t = r1_t2 * r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
        r2_t2     <= r1_t2;
        r2_t3     <= w_t2t[2*F-1:F];
        r2_quot   <= r1_quot;
        r2_rem_nz <= r1_rem_nz;
    end

    // Smoothstep factor 3t^2 - 2t^3, held at one at most
    assign w_t2x3  = {2'b00, r2_t2} + {1'b0, r2_t2, 1'b0};
    assign w_t3x2  = {1'b0, r2_t3, 1'b0};
    assign w_s_raw = w_t2x3 - w_t3x2;
    assign w_s     = (w_s_raw > {1'b0, ONE_Q}) ? ONE_Q : w_s_raw[F:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else begin
            r3_ctl <= r2_ctl;
        end
        r3_s      <= w_s;
        r3_quot   <= r2_quot;
        r3_rem_nz <= r2_rem_nz;
    end

    // Scale the move magnitude by the profile factor
    assign w_prod = i_delta_mag * r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else begin
            r4_ctl <= r3_ctl;
        end
        r4_prod   <= w_prod;
        r4_quot   <= r3_quot;
        r4_rem_nz <= r3_rem_nz;
    end

    assign o_ctl    = r4_ctl;
    assign o_prod   = r4_prod;
    assign o_quot   = r4_quot;
    assign o_rem_nz = r4_rem_nz;

    // Truncated cube never exceeds the truncated square
    a_cube_below_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_ctl.valid |-> (r2_t3 <= r2_t2))
        else $error("t^3 term exceeds t^2 term");

endmodule

[rtl/cubic_linear_trajectory_interpolator.sv]
// Channel     Direction  Handshake                   Payload
// ----------  ---------  --------------------------  ------------------------------
// sample      in         start & !busy               i_current_time
// set-point   out        o_result_valid (1 cycle)    o_position, o_finished
// config      in         i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
// One sample is taken every cycle once busy is low; each result follows its transaction
// through the front stages, the 32-stage restoring divider that retires one quotient
// bit per stage and serves both curve modes, the polynomial stages and the result register.
// Reset is synchronous: it drops samples in flight, zeroes the configuration and
// holds busy high until the first cycle after reset is released.
// Results cannot be stalled by the receiver; the pipeline never holds.
// Configuration is read live, so write it only while no sample is in flight.
module cubic_linear_trajectory_interpolator #(
    parameter int TIME_BITS     = clti_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = clti_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [TIME_BITS-1:0]                i_current_time,
    input  logic                                i_cfg_wr_en,
    input  logic [clti_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [clti_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_result_valid,
    output logic signed [clti_pkg::POS_W-1:0]   o_position,
    output logic                                o_finished
);

    localparam int POS_W   = clti_pkg::POS_W;
    localparam int NUM_W   = POS_W + TIME_BITS;
    localparam int PROD_W  = POS_W + FRACTION_BITS + 1;
    localparam int LAT     = clti_pkg::FRONT_STAGES + POS_W + clti_pkg::POLY_STAGES
                             + clti_pkg::OUT_STAGES;

    logic signed [POS_W-1:0]  r_start_position;
    logic signed [POS_W-1:0]  r_end_position;
    logic [TIME_BITS-1:0]     r_move_duration;
    logic                     r_curve_mode;
    logic                     r_delta_neg;
    logic [POS_W-1:0]         r_delta_mag;
    logic                     r_busy;
    logic                     r_out_valid;
    logic [POS_W-1:0]         r_position;
    logic                     r_finished;

    logic                     w_accept;
    logic [POS_W:0]           w_delta;
    logic [POS_W:0]           w_delta_abs;
    clti_pkg::t_ctl           w_front_ctl;
    logic [NUM_W-1:0]         w_numer;
    clti_pkg::t_ctl           w_div_ctl;
    logic [POS_W-1:0]         w_div_quot;
    logic                     w_div_rem_nz;
    clti_pkg::t_ctl           w_poly_ctl;
    logic [PROD_W-1:0]        w_poly_prod;
    logic [POS_W-1:0]         w_poly_quot;
    logic                     w_poly_rem_nz;
    logic [POS_W-1:0]         w_mag_q;
    logic                     w_frac_nz;
    logic [POS_W-1:0]         w_step;
    logic [POS_W-1:0]         w_pos;
    logic [POS_W-1:0]         n_position;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_position <= '0;
            r_end_position   <= '0;
            r_move_duration  <= '0;
            r_curve_mode     <= clti_pkg::MODE_CUBIC;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                clti_pkg::CFG_START_POSITION: r_start_position <= i_cfg_data[POS_W-1:0];
                clti_pkg::CFG_END_POSITION:   r_end_position   <= i_cfg_data[POS_W-1:0];
                clti_pkg::CFG_MOVE_DURATION:  r_move_duration  <= i_cfg_data[TIME_BITS-1:0];
                clti_pkg::CFG_CURVE_MODE:     r_curve_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sign and magnitude of the move, refreshed every cycle from the registers
    assign w_delta     = {r_end_position[POS_W-1], r_end_position}
                         - {r_start_position[POS_W-1], r_start_position};
    assign w_delta_abs = w_delta[POS_W] ? (~w_delta + 1'b1) : w_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_neg <= 1'b0;
            r_delta_mag <= '0;
        end else begin
            r_delta_neg <= w_delta[POS_W];
            r_delta_mag <= w_delta_abs[POS_W-1:0];
        end
    end

    // Ready in the cycle after reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    clti_front #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_time       (i_current_time),
        .i_duration   (r_move_duration),
        .i_curve_mode (r_curve_mode),
        .i_delta_mag  (r_delta_mag),
        .o_ctl        (w_front_ctl),
        .o_numer      (w_numer)
    );

    clti_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_front_ctl),
        .i_numer   (w_numer),
        .i_divisor (r_move_duration),
        .o_ctl     (w_div_ctl),
        .o_quot    (w_div_quot),
        .o_rem_nz  (w_div_rem_nz)
    );

    clti_poly #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_poly (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_div_ctl),
        .i_quot      (w_div_quot),
        .i_rem_nz    (w_div_rem_nz),
        .i_delta_mag (r_delta_mag),
        .o_ctl       (w_poly_ctl),
        .o_prod      (w_poly_prod),
        .o_quot      (w_poly_quot),
        .o_rem_nz    (w_poly_rem_nz)
    );

    // Pick the scaled magnitude of the active mode and round toward minus infinity
    always_comb begin
        if (r_curve_mode == clti_pkg::MODE_LINEAR) begin
            w_mag_q   = w_poly_quot;
            w_frac_nz = w_poly_rem_nz;
        end else begin
            w_mag_q   = w_poly_prod[POS_W+FRACTION_BITS-1:FRACTION_BITS];
            w_frac_nz = |w_poly_prod[FRACTION_BITS-1:0];
        end
        w_step     = r_delta_neg ? (w_mag_q + {{(POS_W-1){1'b0}}, w_frac_nz}) : w_mag_q;
        w_pos      = r_delta_neg ? (r_start_position - w_step)
                                 : (r_start_position + w_step);
        n_position = w_poly_ctl.done ? r_end_position : w_pos;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_poly_ctl.valid;
        end
        r_position <= n_position;
        r_finished <= w_poly_ctl.done;
    end

    assign o_result_valid = r_out_valid;
    assign o_position     = r_position;
    assign o_finished     = r_finished;

    // Every transaction yields exactly one result at the end of the pipeline
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("accepted sample produced no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    // A finished result always sits on the end position
    a_finished_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_poly_ctl.valid && w_poly_ctl.done) |=> (o_position == $past(r_end_position)))
        else $error("finished result away from end position");

endmodule

[verif/cubic_linear_trajectory_interpolator_tb.sv]
`timescale 1ns / 100ps

module cubic_linear_trajectory_interpolator_tb;

    localparam int TB = clti_pkg::TIME_BITS_DEF;
    localparam int FB = clti_pkg::FRACTION_BITS_DEF;
    localparam int POS_W = clti_pkg::POS_W;
    localparam int CFG_IDX_W = clti_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = clti_pkg::CFG_DATA_W;
    localparam longint unsigned ONE_Q = 64'd1 << FB;
    localparam int LATENCY = 39;
    localparam int ITEMS_PER_MOVE = 75;
    localparam int RANDOM_MOVES = 12;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             finished;
    } t_setpoint;

    // Predicts each set-point from the move registers and holds those still due
    class setpoint_scoreboard;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] end_pos;
        logic [TB-1:0]           duration;
        logic                    mode;
        t_setpoint               due_q[$];
        int unsigned             errors;

        function new();
            start_pos = '0;
            end_pos   = '0;
            duration  = '0;
            mode      = clti_pkg::MODE_CUBIC;
            errors    = 0;
        endfunction

        // Keep only the stated width of each register
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                clti_pkg::CFG_START_POSITION: start_pos = data;
                clti_pkg::CFG_END_POSITION:   end_pos   = data;
                clti_pkg::CFG_MOVE_DURATION:  duration  = data[TB-1:0];
                clti_pkg::CFG_CURVE_MODE:     mode      = data[0];
                default: ;
            endcase
        endfunction

        function t_setpoint interpolate(logic [TB-1:0] tm);
            t_setpoint         sp;
            longint            delta;
            longint            pos;
            longint unsigned   mag;
            longint unsigned   num;
            longint unsigned   den;
            longint unsigned   tq;
            longint unsigned   t2;
            longint unsigned   t3;
            longint unsigned   prod;
            longint unsigned   q;
            bit                neg;
            // Move reached, zero duration included
            if (tm >= duration) begin
                sp.position = end_pos;
                sp.finished = 1'b1;
                return sp;
            end
            sp.finished = 1'b0;
            delta = longint'(end_pos) - longint'(start_pos);
            if (mode == clti_pkg::MODE_LINEAR) begin
                num = tm;
                den = duration;
            end else begin
                // Normalised time, then the smoothstep weight 3t^2 - 2t^3
                tq = (64'(tm) << FB) / 64'(duration);
                if (tq > ONE_Q) tq = ONE_Q;
                t2 = (tq * tq) >> FB;
                t3 = (t2 * tq) >> FB;
                num = 3 * t2 - 2 * t3;
                if (num > ONE_Q) num = ONE_Q;
                den = ONE_Q;
            end
            // Scale the span, flooring toward minus infinity
            neg  = delta < 0;
            mag  = neg ? -delta : delta;
            prod = mag * num;
            q    = prod / den;
            if (neg && (prod % den) != 0) q++;
            pos = neg ? longint'(start_pos) - longint'(q) : longint'(start_pos) + longint'(q);
            sp.position = pos[POS_W-1:0];
            return sp;
        endfunction

        function void note_sample(logic [TB-1:0] tm);
            due_q.push_back(interpolate(tm));
        endfunction

        function void check_setpoint(logic [POS_W-1:0] pos, logic fin);
            t_setpoint want;
            if (due_q.size() == 0) begin
                errors++;
                $error("unexpected set-point: position %h finished %b", pos, fin);
                return;
            end
            want = due_q.pop_front();
            if (pos !== want.position) begin
                errors++;
                $error("position: expected %h, got %h", want.position, pos);
            end
            if (fin !== want.finished) begin
                errors++;
                $error("finished: expected %b, got %b", want.finished, fin);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [TB-1:0]           i_current_time = '0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = clti_pkg::CFG_START_POSITION;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    o_result_valid;
    logic signed [POS_W-1:0] o_position;
    logic                    o_finished;

    setpoint_scoreboard sb = new();
    int unsigned        sent = 0;

    cubic_linear_trajectory_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_current_time (i_current_time),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_position     (o_position),
        .o_finished     (o_finished)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Check every set-point on the cycle it is shown
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1)
            sb.check_setpoint(o_position, o_finished);
    end

    // Idle the sender on its share of cycles, then issue one transaction
    task automatic run_sample(input logic [TB-1:0] tm, input bit last);
        int unsigned pct;
        pct = (sent < 300) ? 16 : (sent < 600) ? 46 : 0;
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_current_time <= tm;
        do @(posedge i_clk); while (busy);
        sb.note_sample(tm);
        sent++;
        if (last) start <= 1'b0;
    endtask

    // Hold the enable across back-to-back writes; the caller drops it
    task automatic write_one(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Load a whole move, with junk in the unused upper bits
    task automatic program_move(input logic [31:0] s, input logic [31:0] e,
                                input logic [TB-1:0] d, input logic m);
        write_one(clti_pkg::CFG_START_POSITION, s);
        write_one(clti_pkg::CFG_END_POSITION, e);
        write_one(clti_pkg::CFG_MOVE_DURATION, {16'($urandom), d});
        write_one(clti_pkg::CFG_CURVE_MODE, {31'($urandom), m});
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until every set-point due has come back
    task automatic settle();
        int n;
        for (n = 0; n < 4 * LATENCY && sb.pending() != 0; n++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_position();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0]   s;
        logic [31:0]   e;
        logic [TB-1:0] d;
        logic [TB-1:0] tm;
        logic          m;
        int            mv;
        int            k;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers straight from reset: zero duration, so already finished
        run_sample(16'h0000, 0);
        run_sample(16'hFFFF, 1);
        settle();

        // Cubic across the full range, longest move
        program_move(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, clti_pkg::MODE_CUBIC);
        run_sample(16'h0000, 0);
        run_sample(16'h0001, 0);
        run_sample(16'h7FFF, 0);
        run_sample(16'hFFFE, 0);
        run_sample(16'hFFFF, 1);
        settle();

        // Cubic falling, very short move
        program_move(32'h7FFF_FFFF, 32'h8000_0000, 16'd3, clti_pkg::MODE_CUBIC);
        run_sample(16'd0, 0);
        run_sample(16'd1, 0);
        run_sample(16'd2, 0);
        run_sample(16'd3, 1);
        settle();

        // Linear across the full range
        program_move(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, clti_pkg::MODE_LINEAR);
        run_sample(16'd0, 0);
        run_sample(16'd1, 0);
        run_sample(16'd40000, 0);
        run_sample(16'hFFFE, 1);
        settle();

        // Linear falling, one-tick move
        program_move(32'h7FFF_FFFF, 32'h8000_0000, 16'd1, clti_pkg::MODE_LINEAR);
        run_sample(16'd0, 0);
        run_sample(16'd1, 1);
        settle();

        // Zero duration in linear mode
        program_move(32'hFFFF_0000, 32'h0001_8000, 16'd0, clti_pkg::MODE_LINEAR);
        run_sample(16'd0, 0);
        run_sample(16'hFFFF, 1);
        settle();

        // No span: start equals end
        program_move(32'h1234_5678, 32'h1234_5678, 16'd100, clti_pkg::MODE_CUBIC);
        run_sample(16'd50, 1);
        settle();

        // Random moves, mostly sampled inside the move
        for (mv = 0; mv < RANDOM_MOVES; mv++) begin
            s = pick_position();
            e = pick_position();
            case ($urandom_range(7))
                0:       d = '0;
                1:       d = '1;
                2, 3:    d = TB'($urandom_range(1, 16));
                default: d = TB'($urandom_range(1, 65535));
            endcase
            m = $urandom_range(1);
            program_move(s, e, d, m);
            for (k = 0; k < ITEMS_PER_MOVE; k++) begin
                if (d != 0 && $urandom_range(9) < 7)
                    tm = TB'($urandom_range(0, d - 1));
                else
                    tm = TB'($urandom);
                run_sample(tm, k == ITEMS_PER_MOVE - 1);
            end
            settle();
        end

        repeat (LATENCY) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $error("%0d set-points never arrived", sb.pending());
        end
        if (sb.errors == 0)
            $display("cubic_linear_trajectory_interpolator_tb OK");
        else
            $display("cubic_linear_trajectory_interpolator_tb NOT OK");
        $finish;
    end

    // Drop the run if it hangs
    initial begin
        #2_000_000;
        $display("cubic_linear_trajectory_interpolator_tb NOT OK");
        $finish;
    end

endmodule
